// ===== rtl/core/bbl_pkg.sv =====
// Shared constants, types and the reciprocal table of the 3x3 box blur.
package bbl_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int POS_ROW_W   = $clog2(MAX_HEIGHT + 2);
   localparam int FW_W        = 11;
   localparam int FH_W        = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [FW_W-1:0] FRAME_WIDTH_MAX    = FW_W'(MAX_WIDTH);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_MAX   = FH_W'(MAX_HEIGHT);

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int CHAN_W      = 8;
   localparam int SUM_W       = 12;
   localparam int COUNT_W     = 4;
   localparam int DIVIDEND_W  = 13;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_W      = DIVIDEND_W + RECIP_W;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   // Index order is [column: 0 oldest][row: 0 top].
   typedef rgb_type [2:0][2:0] window_type;

   typedef struct packed {
      logic [2:0] col_ok;
      logic [2:0] row_ok;
   } mask_type;

   typedef struct packed {
      logic             rd_en;
      logic [COL_W-1:0] rd_addr;
      logic             wr_en;
      logic [COL_W-1:0] wr_addr;
      rgb_type          wr_pixel;
   } ls_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SUM,
      ST_MUL
   } state_type;

   // Rounded mean: floor(n * ceil(2^18 / (2 * count)) / 2^18) with n = 2 * sum + count.
   // The error term stays below 2^18 for every reachable dividend, so the quotient is exact.
   function automatic logic [RECIP_W-1:0] mean_recip(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] recip;
      case (count)
         4'd1:    recip = 18'd131072;
         4'd2:    recip = 18'd65536;
         4'd3:    recip = 18'd43691;
         4'd4:    recip = 18'd32768;
         4'd6:    recip = 18'd21846;
         4'd9:    recip = 18'd14564;
         default: recip = 18'd0;
      endcase
      return recip;
   endfunction

endpackage

// ===== rtl/core/bbl_if.sv =====
// Valid/ready channel interfaces for pixel requests and blurred pixel responses.
interface bbl_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [bbl_pkg::CHAN_W-1:0] in_red;
   logic [bbl_pkg::CHAN_W-1:0] in_green;
   logic [bbl_pkg::CHAN_W-1:0] in_blue;

   modport source (output valid, output op, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink   (input valid, input op, input in_red, input in_green, input in_blue,
                   output ready);
endinterface

interface bbl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bbl_pkg::CHAN_W-1:0] out_red;
   logic [bbl_pkg::CHAN_W-1:0] out_green;
   logic [bbl_pkg::CHAN_W-1:0] out_blue;
   logic [bbl_pkg::ROW_W-1:0]  out_row;
   logic [bbl_pkg::COL_W-1:0]  out_col;
   logic                       last_of_frame;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output out_row, output out_col, output last_of_frame, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input out_row, input out_col, input last_of_frame, output ready);
endinterface

// ===== rtl/core/bbl_line_store.sv =====
// Two line memories holding the previous and the older row, with registered reads.
module bbl_line_store (
   input  logic                clock,
   input  bbl_pkg::ls_cmd_type cmd,
   output bbl_pkg::rgb_type    older_q,
   output bbl_pkg::rgb_type    prev_q
);

   bbl_pkg::rgb_type prev_mem  [bbl_pkg::MAX_WIDTH];
   bbl_pkg::rgb_type older_mem [bbl_pkg::MAX_WIDTH];
   bbl_pkg::rgb_type prev_q_ff;
   bbl_pkg::rgb_type older_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         prev_q_ff  <= prev_mem[cmd.rd_addr];
         older_q_ff <= older_mem[cmd.rd_addr];
      end
   end

   // The row that was previous moves down to older as the new pixel takes its place.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         older_mem[cmd.wr_addr] <= prev_q_ff;
         prev_mem[cmd.wr_addr]  <= cmd.wr_pixel;
      end
   end

   assign older_q = older_q_ff;
   assign prev_q  = prev_q_ff;

endmodule

// ===== rtl/core/bbl_mean.sv =====
// Masked window sums per channel, then a rounded mean by reciprocal multiplication.
module bbl_mean (
   input  logic                clock,
   input  logic                load,
   input  bbl_pkg::window_type window,
   input  bbl_pkg::mask_type   mask,
   output bbl_pkg::rgb_type    mean
);

   logic [bbl_pkg::SUM_W-1:0]      sum_red;
   logic [bbl_pkg::SUM_W-1:0]      sum_green;
   logic [bbl_pkg::SUM_W-1:0]      sum_blue;
   logic [bbl_pkg::COUNT_W-1:0]    count;
   logic [bbl_pkg::SUM_W-1:0]      sum_red_ff;
   logic [bbl_pkg::SUM_W-1:0]      sum_green_ff;
   logic [bbl_pkg::SUM_W-1:0]      sum_blue_ff;
   logic [bbl_pkg::COUNT_W-1:0]    count_ff;
   logic [bbl_pkg::RECIP_W-1:0]    recip_ff;
   logic [bbl_pkg::DIVIDEND_W-1:0] num_red;
   logic [bbl_pkg::DIVIDEND_W-1:0] num_green;
   logic [bbl_pkg::DIVIDEND_W-1:0] num_blue;
   logic [bbl_pkg::PROD_W-1:0]     prod_red;
   logic [bbl_pkg::PROD_W-1:0]     prod_green;
   logic [bbl_pkg::PROD_W-1:0]     prod_blue;

   always_comb begin
      sum_red   = '0;
      sum_green = '0;
      sum_blue  = '0;
      count     = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if (mask.col_ok[c] && mask.row_ok[r]) begin
               sum_red   = sum_red + bbl_pkg::SUM_W'(window[c][r].red);
               sum_green = sum_green + bbl_pkg::SUM_W'(window[c][r].green);
               sum_blue  = sum_blue + bbl_pkg::SUM_W'(window[c][r].blue);
               count     = count + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_red_ff   <= sum_red;
         sum_green_ff <= sum_green;
         sum_blue_ff  <= sum_blue;
         count_ff     <= count;
         recip_ff     <= bbl_pkg::mean_recip(count);
      end
   end

   always_comb begin
      num_red    = {sum_red_ff, 1'b0} + bbl_pkg::DIVIDEND_W'(count_ff);
      num_green  = {sum_green_ff, 1'b0} + bbl_pkg::DIVIDEND_W'(count_ff);
      num_blue   = {sum_blue_ff, 1'b0} + bbl_pkg::DIVIDEND_W'(count_ff);
      prod_red   = bbl_pkg::PROD_W'(num_red) * bbl_pkg::PROD_W'(recip_ff);
      prod_green = bbl_pkg::PROD_W'(num_green) * bbl_pkg::PROD_W'(recip_ff);
      prod_blue  = bbl_pkg::PROD_W'(num_blue) * bbl_pkg::PROD_W'(recip_ff);
      mean.red   = prod_red[bbl_pkg::RECIP_SHIFT +: bbl_pkg::CHAN_W];
      mean.green = prod_green[bbl_pkg::RECIP_SHIFT +: bbl_pkg::CHAN_W];
      mean.blue  = prod_blue[bbl_pkg::RECIP_SHIFT +: bbl_pkg::CHAN_W];
   end

endmodule

// ===== rtl/core/box_blur_3x3_edge_average.sv =====
// Top level of the 3x3 box blur with edge-aware averaging over a raster pixel stream.
//
// Pixels enter on the req channel in raster order (op low); drain transfers (op high)
// push the stream on past the end of a frame to flush the last outputs. Each output
// on the rsp channel is the rounded per-channel mean of the in-frame 3x3 neighbors,
// with its row, column and a last-of-frame flag, frame_width + 1 positions behind.
// A drain that arrives before the whole frame is in, or after its last output, is
// dropped. A pixel arriving while drains are still owed starts a new frame.
// An accepted transfer that yields no output passes through the line-store read and
// the window update and write-back; one that yields an output goes on through the
// masked sums and the reciprocal multiply into the output register.
// The output register lets the next transfer be accepted while a result waits; a
// stalled receiver holds the block in its last step only once a second result is ready.
// Synchronous reset sets the frame to 640 by 480 and clears all positions; the line
// stores need no clearing. Writing either csr register restarts the frame at row 0.
module box_blur_3x3_edge_average (
   input  logic                               clock,
   input  logic                               reset,
   bbl_req_if.sink                            req,
   bbl_rsp_if.source                          rsp,
   input  logic                               csr_wr_en,
   input  logic [bbl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bbl_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   bbl_pkg::state_type             state_ff;
   bbl_pkg::state_type             state_in;
   logic [bbl_pkg::FW_W-1:0]       width_ff;
   logic [bbl_pkg::FH_W-1:0]       height_ff;
   logic [bbl_pkg::COL_W-1:0]      in_col_ff;
   logic [bbl_pkg::POS_ROW_W-1:0]  in_row_ff;
   logic [bbl_pkg::COL_W-1:0]      out_col_ff;
   logic [bbl_pkg::ROW_W-1:0]      out_row_ff;
   bbl_pkg::rgb_type               pix_ff;
   logic                           real_ff;
   logic [bbl_pkg::COL_W-1:0]      col_ff;
   bbl_pkg::window_type            win_ff;
   bbl_pkg::mask_type              mask_ff;
   bbl_pkg::mask_type              mask_in;
   logic [bbl_pkg::ROW_W-1:0]      emit_row_ff;
   logic [bbl_pkg::COL_W-1:0]      emit_col_ff;
   logic                           emit_last_ff;
   logic                           rsp_valid_ff;
   bbl_pkg::rgb_type               rsp_pix_ff;
   logic [bbl_pkg::ROW_W-1:0]      rsp_row_ff;
   logic [bbl_pkg::COL_W-1:0]      rsp_col_ff;
   logic                           rsp_last_ff;

   logic                           req_ready;
   logic                           accept;
   logic                           row_done;
   logic                           restart_on_pixel;
   logic                           start;
   logic                           update;
   logic                           sum_load;
   logic                           rsp_load;
   logic                           rsp_free;
   logic                           col_wrap;
   logic                           emit;
   logic                           last;
   logic [bbl_pkg::FW_W-1:0]       in_col_next;
   logic [bbl_pkg::FW_W-1:0]       out_col_next;
   logic [bbl_pkg::FH_W-1:0]       out_row_next;
   logic [bbl_pkg::FW_W-1:0]       csr_width;
   logic [bbl_pkg::FH_W-1:0]       csr_height;
   bbl_pkg::ls_cmd_type            ls_cmd;
   bbl_pkg::rgb_type               older_q;
   bbl_pkg::rgb_type               prev_q;
   bbl_pkg::rgb_type               mean;

   assign row_done         = in_row_ff >= height_ff;
   assign restart_on_pixel = (req.op == bbl_pkg::OP_PIXEL) && row_done;
   assign rsp_free         = !rsp_valid_ff || rsp.ready;

   assign in_col_next  = {1'b0, in_col_ff} + 1'b1;
   assign col_wrap     = in_col_next >= width_ff;
   assign emit         = (|in_row_ff[bbl_pkg::POS_ROW_W-1:1]) || (in_row_ff[0] && |in_col_ff);
   assign out_col_next = {1'b0, out_col_ff} + 1'b1;
   assign out_row_next = {1'b0, out_row_ff} + 1'b1;

   always_comb begin
      mask_in.col_ok = {out_col_next < width_ff, 1'b1, out_col_ff != '0};
      mask_in.row_ok = {out_row_next < height_ff, 1'b1, out_row_ff != '0};
      last           = !mask_in.col_ok[2] && !mask_in.row_ok[2];
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      start            = 1'b0;
      update           = 1'b0;
      sum_load         = 1'b0;
      rsp_load         = 1'b0;
      ls_cmd.rd_en     = 1'b0;
      ls_cmd.rd_addr   = restart_on_pixel ? '0 : in_col_ff;
      ls_cmd.wr_en     = 1'b0;
      ls_cmd.wr_addr   = col_ff;
      ls_cmd.wr_pixel  = pix_ff;
      accept           = 1'b0;
      unique case (state_ff)
         bbl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req.valid;
            if (req.valid && ((req.op == bbl_pkg::OP_PIXEL) || row_done)) begin
               start        = 1'b1;
               ls_cmd.rd_en = 1'b1;
               state_in     = bbl_pkg::ST_UPDATE;
            end
         end
         bbl_pkg::ST_UPDATE: begin
            update       = 1'b1;
            ls_cmd.wr_en = real_ff;
            state_in     = emit ? bbl_pkg::ST_SUM : bbl_pkg::ST_IDLE;
         end
         bbl_pkg::ST_SUM: begin
            sum_load = 1'b1;
            state_in = bbl_pkg::ST_MUL;
         end
         bbl_pkg::ST_MUL: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = bbl_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      csr_width  = csr_wr_data[bbl_pkg::FW_W-1:0];
      csr_height = csr_wr_data[bbl_pkg::FH_W-1:0];
      if (csr_width == '0) begin
         csr_width = 11'd1;
      end else if (csr_width > bbl_pkg::FRAME_WIDTH_MAX) begin
         csr_width = bbl_pkg::FRAME_WIDTH_MAX;
      end
      if (csr_height == '0) begin
         csr_height = 13'd1;
      end else if (csr_height > bbl_pkg::FRAME_HEIGHT_MAX) begin
         csr_height = bbl_pkg::FRAME_HEIGHT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bbl_pkg::FRAME_WIDTH_RESET;
         height_ff    <= bbl_pkg::FRAME_HEIGHT_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               bbl_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_width;
               bbl_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_height;
            endcase
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (start && restart_on_pixel) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (update) begin
            if (emit && last) begin
               in_col_ff  <= '0;
               in_row_ff  <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
            end else begin
               if (col_wrap) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + 1'b1;
               end else begin
                  in_col_ff <= in_col_next[bbl_pkg::COL_W-1:0];
               end
               if (emit) begin
                  if (!mask_in.col_ok[2]) begin
                     out_col_ff <= '0;
                     out_row_ff <= out_row_next[bbl_pkg::ROW_W-1:0];
                  end else begin
                     out_col_ff <= out_col_next[bbl_pkg::COL_W-1:0];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pix_ff  <= '{red: req.in_red, green: req.in_green, blue: req.in_blue};
         real_ff <= (req.op == bbl_pkg::OP_PIXEL);
         col_ff  <= ls_cmd.rd_addr;
      end
      if (update) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1]    <= win_ff[2];
         win_ff[2][0] <= older_q;
         win_ff[2][1] <= prev_q;
         win_ff[2][2] <= real_ff ? pix_ff : '0;
         mask_ff      <= mask_in;
         emit_row_ff  <= out_row_ff;
         emit_col_ff  <= out_col_ff;
         emit_last_ff <= last;
      end
      if (rsp_load) begin
         rsp_pix_ff  <= mean;
         rsp_row_ff  <= emit_row_ff;
         rsp_col_ff  <= emit_col_ff;
         rsp_last_ff <= emit_last_ff;
      end
   end

   bbl_line_store u_line_store (
      .clock   (clock),
      .cmd     (ls_cmd),
      .older_q (older_q),
      .prev_q  (prev_q)
   );

   bbl_mean u_mean (
      .clock  (clock),
      .load   (sum_load),
      .window (win_ff),
      .mask   (mask_ff),
      .mean   (mean)
   );

   assign req.ready         = req_ready;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_red       = rsp_pix_ff.red;
   assign rsp.out_green     = rsp_pix_ff.green;
   assign rsp.out_blue      = rsp_pix_ff.blue;
   assign rsp.out_row       = rsp_row_ff;
   assign rsp.out_col       = rsp_col_ff;
   assign rsp.last_of_frame = rsp_last_ff;

   a_in_row_bound: assert property (@(posedge clock) disable iff (reset)
      (accept || !accept) |-> in_row_ff <= height_ff + 1'b1)
      else $error("input row ran past the drain region");

   a_out_in_frame: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, out_col_ff} < width_ff) && ({1'b0, out_row_ff} < height_ff))
      else $error("output position left the frame");

   a_rsp_from_mul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == bbl_pkg::ST_MUL)
      else $error("response raised outside the multiply step");

   a_sum_then_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == bbl_pkg::ST_SUM |=> state_ff == bbl_pkg::ST_MUL)
      else $error("sum step not followed by multiply step");

endmodule
